// File: src/mtep_pkg.sv
// ============================================================================
// mtep_pkg : MIDI track event parser shared definitions
// Parse phases, parser state, result item layout and status helpers.
// ============================================================================
package mtep_pkg;

    localparam int DeltaWidth = 28;
    localparam int CountWidth = 3;

    localparam logic [7:0] StatusMeta   = 8'hFF;
    localparam logic [7:0] NibbleMask   = 8'hF0;
    localparam logic [7:0] NibbleSystem = 8'hF0;
    localparam logic [7:0] MetaEot      = 8'h2F;
    localparam logic [CountWidth-1:0] VlqMaxBytes = 3'd4;

    typedef enum logic [7:0] {
        PH_DELTA  = 8'b0000_0001,
        PH_STATUS = 8'b0000_0010,
        PH_DATA1  = 8'b0000_0100,
        PH_DATA2  = 8'b0000_1000,
        PH_MTYPE  = 8'b0001_0000,
        PH_MLEN   = 8'b0010_0000,
        PH_MSKIP  = 8'b0100_0000,
        PH_HALT   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [DeltaWidth-1:0] delta;
        logic [CountWidth-1:0] count;
        logic [7:0]            running;
        logic [6:0]            data_one;
        logic [7:0]            meta_type;
        logic [DeltaWidth-1:0] skip;
    } parse_state_t;

    typedef struct packed {
        logic [DeltaWidth-1:0] delta_ticks;
        logic [7:0]            status_code;
        logic [6:0]            data_one;
        logic [6:0]            data_two;
        logic                  is_meta;
        logic                  track_end;
        logic                  parse_error;
    } result_t;

    localparam parse_state_t StateReset = '{
        phase:     PH_DELTA,
        delta:     '0,
        count:     '0,
        running:   '0,
        data_one:  '0,
        meta_type: '0,
        skip:      '0
    };

    function automatic logic two_data(input logic [7:0] st);
        logic [3:0] n;
        n = st[7:4];
        return (n inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hE});
    endfunction

    function automatic logic valid_status(input logic [7:0] st);
        return st[7] && ((st & NibbleMask) != NibbleSystem);
    endfunction

endpackage

// File: src/midi_track_event_parser_core.sv
// ============================================================================
// midi_track_event_parser_core : MIDI track event parser
// Parse track bytes into channel and meta event items with running status.
// ============================================================================
// Usage:
//   The slave channel carries one track byte per item in s_tdata, with
//   s_tuser set on the first byte of a track to clear running status and
//   the parse state. Each finished event, or an error, leaves as one item
//   on the master channel; the end of track flag rides on m_tlast.
//   A byte is taken every cycle while s_tready is high. The parser state
//   advances in the cycle the byte is accepted, and the result item shows
//   on the master channel in the following cycle from the result register.
//   Bytes that finish no event give no item. After an error the parser
//   holds and drops bytes until a byte with the track start flag arrives.
//   At reset the parser waits for a delta time with no running status and
//   the result register is empty.
//   When the receiver stalls, one result item waits in the result register
//   and further bytes are still taken as long as that register is free or
//   being emptied in the same cycle; s_tready falls only while a waiting
//   item is not taken.
// ============================================================================
module midi_track_event_parser_core
    import mtep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] track_byte
    input  logic [0:0]  s_tuser,   // [0] track_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [27:0] delta_ticks, [35:28] status_code,
                                   // [42:36] data_one, [49:43] data_two, zero fill
    output logic [1:0]  m_tuser,   // [0] is_meta, [1] parse_error
    output logic        m_tlast    // track_end
);

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         res_valid;
    result_t      res;
    logic         can_load;
    logic         accept;
    result_t      out_res;

    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    mtep_step u_step (
        .state       (state_reg),
        .track_byte  (s_tdata),
        .track_start (s_tuser[0]),
        .state_next  (state_next),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= StateReset;
        else if (accept)
            state_reg <= state_next;
    end

    mtep_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_valid),
        .res       (res),
        .out_ready (m_tready),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_res   (out_res)
    );

    assign m_tdata = {6'd0, out_res.data_two, out_res.data_one,
                      out_res.status_code, out_res.delta_ticks};
    assign m_tuser = {out_res.parse_error, out_res.is_meta};
    assign m_tlast = out_res.track_end;

endmodule

// File: src/mtep_step.sv
// ============================================================================
// mtep_step : parser next-state logic
// Work out the next parser state and any result item for one track byte.
// ============================================================================
module mtep_step
    import mtep_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   track_byte,
    input  logic         track_start,
    output parse_state_t state_next,
    output logic         res_valid,
    output result_t      res
);

    parse_state_t          cur;
    logic [DeltaWidth-1:0] vlq_delta;
    logic [DeltaWidth-1:0] vlq_skip;
    logic [DeltaWidth-1:0] skip_dec;
    logic [CountWidth-1:0] count_inc;

    always_comb
    begin
        cur       = track_start ? StateReset : state;
        vlq_delta = {cur.delta[DeltaWidth-8:0], track_byte[6:0]};
        vlq_skip  = {cur.skip[DeltaWidth-8:0], track_byte[6:0]};
        skip_dec  = cur.skip - DeltaWidth'(1);
        count_inc = cur.count + CountWidth'(1);

        state_next = cur;
        res_valid  = 1'b0;
        res        = '0;

        case (cur.phase)
            PH_DELTA:
            begin
                state_next.delta = vlq_delta;
                state_next.count = count_inc;
                if (track_byte[7])
                begin
                    if (count_inc >= VlqMaxBytes)
                    begin
                        res.parse_error  = 1'b1;
                        res_valid        = 1'b1;
                        state_next.phase = PH_HALT;
                    end
                end
                else
                begin
                    state_next.phase = PH_STATUS;
                end
            end
            PH_STATUS, PH_DATA1:
            begin
                res.delta_ticks = cur.delta;
                if (cur.phase == PH_STATUS && track_byte == StatusMeta)
                begin
                    state_next.running = '0;
                    state_next.phase   = PH_MTYPE;
                end
                else if (cur.phase == PH_STATUS && track_byte[7])
                begin
                    state_next.running = track_byte;
                    if (!valid_status(track_byte))
                    begin
                        res.status_code  = track_byte;
                        res.parse_error  = 1'b1;
                        res_valid        = 1'b1;
                        state_next.phase = PH_HALT;
                    end
                    else
                    begin
                        state_next.phase = PH_DATA1;
                    end
                end
                else if (cur.phase == PH_STATUS && !valid_status(cur.running))
                begin
                    res.status_code  = cur.running;
                    res.parse_error  = 1'b1;
                    res_valid        = 1'b1;
                    state_next.phase = PH_HALT;
                end
                else
                begin
                    state_next.data_one = track_byte[6:0];
                    if (two_data(cur.running))
                    begin
                        state_next.phase = PH_DATA2;
                    end
                    else
                    begin
                        res.status_code  = cur.running;
                        res.data_one     = track_byte[6:0];
                        res_valid        = 1'b1;
                        state_next.phase = PH_DELTA;
                        state_next.delta = '0;
                        state_next.count = '0;
                    end
                end
            end
            PH_DATA2:
            begin
                res.delta_ticks  = cur.delta;
                res.status_code  = cur.running;
                res.data_one     = cur.data_one;
                res.data_two     = track_byte[6:0];
                res_valid        = 1'b1;
                state_next.phase = PH_DELTA;
                state_next.delta = '0;
                state_next.count = '0;
            end
            PH_MTYPE:
            begin
                state_next.meta_type = track_byte;
                state_next.skip      = '0;
                state_next.count     = '0;
                state_next.phase     = PH_MLEN;
            end
            PH_MLEN:
            begin
                res.delta_ticks  = cur.delta;
                res.status_code  = cur.meta_type;
                res.is_meta      = 1'b1;
                res.track_end    = (cur.meta_type == MetaEot);
                state_next.skip  = vlq_skip;
                state_next.count = count_inc;
                if (track_byte[7])
                begin
                    if (count_inc >= VlqMaxBytes)
                    begin
                        res.parse_error  = 1'b1;
                        res_valid        = 1'b1;
                        state_next.phase = PH_HALT;
                    end
                end
                else if (vlq_skip != '0)
                begin
                    state_next.phase = PH_MSKIP;
                end
                else
                begin
                    res_valid        = 1'b1;
                    state_next.phase = PH_DELTA;
                    state_next.delta = '0;
                    state_next.count = '0;
                end
            end
            PH_MSKIP:
            begin
                res.delta_ticks  = cur.delta;
                res.status_code  = cur.meta_type;
                res.is_meta      = 1'b1;
                res.track_end    = (cur.meta_type == MetaEot);
                state_next.skip  = skip_dec;
                if (skip_dec == '0)
                begin
                    res_valid        = 1'b1;
                    state_next.phase = PH_DELTA;
                    state_next.delta = '0;
                    state_next.count = '0;
                end
            end
            default:
            begin
                state_next = cur;
            end
        endcase
    end

endmodule

// File: src/mtep_out_reg.sv
// ============================================================================
// mtep_out_reg : result item register
// Hold one result item for the downstream side and report when it can load.
// ============================================================================
module mtep_out_reg
    import mtep_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_ready,
    output logic    can_load,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

endmodule

// File: test/tb_top.sv
// ============================================================================
// tb_top : MIDI track event parser testbench
// Drives track bytes through the slave stream and checks every event item
// on the master stream against an in-bench parser of the same byte format.
// A directed track comes first, then random tracks that are mostly well
// formed: channel messages, running status and meta events. The rest are
// parse errors, bytes dropped while holding, and track restarts mid-event.
// The run passes through four idling phases and one long receiver hold-off.
// ============================================================================
class track_event_checker;
    mtep_pkg::phase_t phase;
    logic [27:0]      delta_acc;
    logic [2:0]       vlq_count;
    logic [7:0]       running;
    logic [6:0]       held_data;
    logic [7:0]       meta_kind;
    logic [27:0]      skip_left;
    mtep_pkg::result_t expected_events[$];
    int               mismatches;
    int               checked;
    int               meta_seen;
    int               errors_seen;

    function new();
        restart_track();
        mismatches  = 0;
        checked     = 0;
        meta_seen   = 0;
        errors_seen = 0;
    endfunction

    static function bit status_ok(logic [7:0] st);
        return st[7] && (st[7:4] != 4'hF);
    endfunction

    static function bit has_two(logic [7:0] st);
        return st[7:4] inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hE};
    endfunction

    function void restart_track();
        next_event();
        running   = '0;
        held_data = '0;
        meta_kind = '0;
        skip_left = '0;
    endfunction

    function void next_event();
        phase     = mtep_pkg::PH_DELTA;
        delta_acc = '0;
        vlq_count = '0;
    endfunction

    function void push_event(logic [27:0] d, logic [7:0] st, logic [6:0] d1,
                             logic [6:0] d2, logic meta, logic err);
        mtep_pkg::result_t ev;
        ev.delta_ticks  = d;
        ev.status_code  = st;
        ev.data_one     = d1;
        ev.data_two     = d2;
        ev.is_meta      = meta;
        ev.track_end    = meta && (st == mtep_pkg::MetaEot);
        ev.parse_error  = err;
        expected_events.push_back(ev);
    endfunction

    function void note_byte(logic [7:0] b, logic start);
        if (start)
            restart_track();
        // a data byte under running status goes straight to the first data slot
        if (phase == mtep_pkg::PH_STATUS && !b[7] && status_ok(running))
            phase = mtep_pkg::PH_DATA1;
        case (phase)
            mtep_pkg::PH_DELTA:
            begin
                delta_acc = {delta_acc[20:0], b[6:0]};
                vlq_count = vlq_count + 3'd1;
                if (!b[7])
                    phase = mtep_pkg::PH_STATUS;
                else if (vlq_count >= 3'd4)
                begin
                    push_event('0, '0, '0, '0, 1'b0, 1'b1);
                    phase = mtep_pkg::PH_HALT;
                end
            end
            mtep_pkg::PH_STATUS:
            begin
                if (b == mtep_pkg::StatusMeta)
                begin
                    running = '0;
                    phase   = mtep_pkg::PH_MTYPE;
                end
                else if (b[7])
                begin
                    running = b;
                    if (status_ok(b))
                        phase = mtep_pkg::PH_DATA1;
                    else
                    begin
                        push_event(delta_acc, b, '0, '0, 1'b0, 1'b1);
                        phase = mtep_pkg::PH_HALT;
                    end
                end
                else
                begin
                    push_event(delta_acc, running, '0, '0, 1'b0, 1'b1);
                    phase = mtep_pkg::PH_HALT;
                end
            end
            mtep_pkg::PH_DATA1:
            begin
                held_data = b[6:0];
                if (has_two(running))
                    phase = mtep_pkg::PH_DATA2;
                else
                begin
                    push_event(delta_acc, running, held_data, '0, 1'b0, 1'b0);
                    next_event();
                end
            end
            mtep_pkg::PH_DATA2:
            begin
                push_event(delta_acc, running, held_data, b[6:0], 1'b0, 1'b0);
                next_event();
            end
            mtep_pkg::PH_MTYPE:
            begin
                meta_kind = b;
                skip_left = '0;
                vlq_count = '0;
                phase     = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN:
            begin
                skip_left = {skip_left[20:0], b[6:0]};
                vlq_count = vlq_count + 3'd1;
                if (b[7])
                begin
                    if (vlq_count >= 3'd4)
                    begin
                        push_event(delta_acc, meta_kind, '0, '0, 1'b1, 1'b1);
                        phase = mtep_pkg::PH_HALT;
                    end
                end
                else if (skip_left != '0)
                    phase = mtep_pkg::PH_MSKIP;
                else
                begin
                    push_event(delta_acc, meta_kind, '0, '0, 1'b1, 1'b0);
                    next_event();
                end
            end
            mtep_pkg::PH_MSKIP:
            begin
                skip_left = skip_left - 28'd1;
                if (skip_left == '0)
                begin
                    push_event(delta_acc, meta_kind, '0, '0, 1'b1, 1'b0);
                    next_event();
                end
            end
            default: ;
        endcase
    endfunction

    function void compare_field(string name, logic [27:0] want, logic [27:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_event(mtep_pkg::result_t got);
        mtep_pkg::result_t want;
        checked++;
        if (got.is_meta)
            meta_seen++;
        if (got.parse_error)
            errors_seen++;
        if (expected_events.size() == 0)
        begin
            $display("%0t: unexpected item, expected none actual %p", $time, got);
            mismatches++;
            return;
        end
        want = expected_events.pop_front();
        compare_field("delta_ticks", want.delta_ticks, got.delta_ticks);
        compare_field("status_code", 28'(want.status_code), 28'(got.status_code));
        compare_field("data_one", 28'(want.data_one), 28'(got.data_one));
        compare_field("data_two", 28'(want.data_two), 28'(got.data_two));
        compare_field("is_meta", 28'(want.is_meta), 28'(got.is_meta));
        compare_field("track_end", 28'(want.track_end), 28'(got.track_end));
        compare_field("parse_error", 28'(want.parse_error), 28'(got.parse_error));
    endfunction
endclass

module tb_top;
    import mtep_pkg::*;

    localparam int ByteTarget = 1650;
    localparam int CycleLimit = 200000;
    localparam int HoldAt     = 150;
    localparam int HoldCycles = 300;

    localparam logic [7:0] DirectedBytes [26] = '{
        8'h00, 8'h90, 8'h3C, 8'h7F,
        8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC5, 8'h80,
        8'h00, 8'h7F,
        8'h00, 8'hFF, 8'h2F, 8'h00,
        8'h00, 8'hFF, 8'h01, 8'h80, 8'h80, 8'h80, 8'h01, 8'h41,
        8'h00, 8'hF3
    };

    typedef struct {
        logic [7:0] value;
        logic       first;
    } track_item_t;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {BAD_STATUS, NO_RUNNING, LONG_DELTA, LONG_LENGTH} fault_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;   // [27:0] delta_ticks, [35:28] status_code,
                            // [42:36] data_one, [49:43] data_two, zero fill
    logic [1:0]  m_tuser;   // [0] is_meta, [1] parse_error
    logic        m_tlast;   // track_end

    track_event_checker parser_check = new();
    track_item_t        stim[$];
    bit                 start_pending;
    int                 accepted_bytes = 0;
    int                 tracks_built   = 0;
    int                 cycle_count    = 0;
    int                 hold_left      = 0;
    bit                 hold_done      = 1'b0;

    midi_track_event_parser_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void add_byte(logic [7:0] value);
        track_item_t it;
        it.value      = value;
        it.first      = start_pending;
        start_pending = 1'b0;
        stim.push_back(it);
    endfunction

    function automatic void add_vlq(int unsigned value, int nbytes);
        logic [7:0] grp;
        for (int k = nbytes - 1; k >= 0; k--)
        begin
            grp = 8'((value >> (7 * k)) & 32'h7F);
            if (k != 0)
                grp[7] = 1'b1;
            add_byte(grp);
        end
    endfunction

    function automatic void add_delta();
        int          r;
        int          n;
        int unsigned v;
        r = $urandom_range(0, 99);
        n = (r < 60) ? 1 : (r < 80) ? 2 : (r < 90) ? 3 : 4;
        v = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom;
        v = v & ((32'd1 << (7 * n)) - 32'd1);
        add_vlq(v, n);
    endfunction

    function automatic void add_data_byte();
        if ($urandom_range(0, 9) == 0)
            add_byte(8'($urandom));
        else
            add_byte(8'($urandom_range(0, 127)));
    endfunction

    function automatic void add_meta(logic [7:0] kind);
        int len;
        int nlen;
        len  = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 4);
        nlen = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
        if (len > 127 && nlen < 2)
            nlen = 2;
        add_byte(StatusMeta);
        add_byte(kind);
        add_vlq(len, nlen);
        repeat (len) add_byte(8'($urandom));
    endfunction

    function automatic void add_fault(bit rs_ok);
        fault_t kind;
        kind = fault_t'($urandom_range(0, 3));
        case (kind)
            BAD_STATUS:
            begin
                add_delta();
                add_byte(8'($urandom_range(8'hF0, 8'hFE)));
            end
            NO_RUNNING:
            begin
                if (rs_ok)
                begin
                    add_byte(8'h00);
                    add_byte(StatusMeta);
                    add_byte(8'h01);
                    add_byte(8'h00);
                end
                add_delta();
                add_byte(8'($urandom_range(0, 127)));
            end
            LONG_DELTA:
                repeat (4) add_byte(8'($urandom) | 8'h80);
            LONG_LENGTH:
            begin
                add_delta();
                add_byte(StatusMeta);
                add_byte(8'($urandom));
                repeat (4) add_byte(8'($urandom) | 8'h80);
            end
            default: ;
        endcase
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
    endfunction

    function automatic void add_track();
        int         r;
        logic [7:0] st;
        logic [7:0] last_st;
        logic [7:0] kind;
        bit         rs_ok;
        start_pending = 1'b1;
        rs_ok         = 1'b0;
        last_st       = 8'h90;
        tracks_built++;
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(5, 15)) add_byte(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 12))
        begin
            add_delta();
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 65 && !rs_ok))
            begin
                st = {4'($urandom_range(8, 14)), 4'($urandom)};
                add_byte(st);
                last_st = st;
                rs_ok   = 1'b1;
                add_data_byte();
                if (two_data(st))
                    add_data_byte();
            end
            else if (r < 65)
            begin
                add_byte(8'($urandom_range(0, 127)));
                if (two_data(last_st))
                    add_data_byte();
            end
            else
            begin
                kind = ($urandom_range(0, 3) == 0) ? MetaEot : 8'($urandom);
                add_meta(kind);
                rs_ok = 1'b0;
                if (kind == MetaEot && $urandom_range(0, 1) == 0)
                    return;
            end
        end
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            add_delta();
            add_byte(StatusMeta);
            add_byte(MetaEot);
            add_byte(8'h00);
        end
        else if (r < 80)
            add_fault(rs_ok);
        else
        begin
            add_delta();
            if ($urandom_range(0, 1) == 0)
                add_byte({4'($urandom_range(8, 14)), 4'($urandom)});
        end
    endfunction

    function automatic idle_mode_t current_mode();
        return idle_mode_t'((accepted_bytes * 4) / (stim.size() + 1));
    endfunction

    function automatic int idle_pct(bit receiver_side);
        case (current_mode())
            IDLE_SENDER:   return receiver_side ? 0 : 75;
            IDLE_RECEIVER: return receiver_side ? 75 : 0;
            IDLE_BOTH:     return 14;
            default:       return 0;
        endcase
    endfunction

    task automatic send_bytes();
        int pct;
        foreach (stim[i])
        begin
            pct = idle_pct(1'b0);
            while ($urandom_range(0, 99) < pct)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stim[i].value;
            s_tuser  <= stim[i].first;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            @(negedge clk);
        end
        s_tvalid <= 1'b0;
    endtask

    // hold off once for a long stretch, otherwise stall as the phase says
    always @(negedge clk)
    begin
        if (!hold_done && accepted_bytes >= HoldAt)
        begin
            hold_done <= 1'b1;
            hold_left <= HoldCycles;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                parser_check.check_event('{
                    delta_ticks:  m_tdata[27:0],
                    status_code:  m_tdata[35:28],
                    data_one:     m_tdata[42:36],
                    data_two:     m_tdata[49:43],
                    is_meta:      m_tuser[0],
                    track_end:    m_tlast,
                    parse_error:  m_tuser[1]
                });
            if (s_tvalid && s_tready)
            begin
                parser_check.note_byte(s_tdata, s_tuser[0]);
                accepted_bytes <= accepted_bytes + 1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d items still expected",
                 cycle_count, parser_check.expected_events.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        start_pending = 1'b1;
        foreach (DirectedBytes[k])
            add_byte(DirectedBytes[k]);
        while (stim.size() < $size(DirectedBytes) + ByteTarget)
            add_track();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_bytes();
        while (parser_check.expected_events.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d track bytes in %0d tracks, %0d event items checked (%0d meta, %0d error)",
                 accepted_bytes, tracks_built, parser_check.checked,
                 parser_check.meta_seen, parser_check.errors_seen);
        $display("idling phases: none, sender, receiver, both; one hold-off of %0d cycles",
                 HoldCycles);
        if (parser_check.mismatches == 0 && parser_check.expected_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// File: midi_track_event_parser_core.f
src/mtep_pkg.sv
src/mtep_step.sv
src/mtep_out_reg.sv
src/midi_track_event_parser_core.sv
test/tb_top.sv
